[rtl/core/ptt_pkg.sv]
// Package for the periodic task timer table: transfer structs, slot record,
// function and event codes. No dependencies.
`timescale 1ns / 1ps

package ptt_pkg;

  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam logic [2:0] EV_CREATED   = 3'd0;
  localparam logic [2:0] EV_DELETED   = 3'd1;
  localparam logic [2:0] EV_NOT_FOUND = 3'd2;
  localparam logic [2:0] EV_FULL      = 3'd3;
  localparam logic [2:0] EV_FIRED     = 3'd4;
  localparam logic [2:0] EV_IDLE      = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [30:0] period_ms;
    logic [30:0] first_delay_ms;
    logic [31:0] target_id;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] timer_id;
    logic        rearmed;
    logic        last_result;
  } result_t;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] due;
    logic [30:0] period;
  } slot_t;

endpackage

[rtl/core/ptt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is requested. No dependencies.
`timescale 1ns / 1ps

module ptt_ram #(
  parameter int WIDTH = 95,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/periodic_task_timer_table.sv]
// Top level of the periodic task timer table: sequencer, shared adder and slot
// scan. Depends on ptt_pkg and ptt_ram.
`timescale 1ns / 1ps

// A table of TIMER_SLOTS one-shot and periodic timers. Present an item on
// "item" with start high while busy is low; that edge is the transfer. Func
// create takes the lowest free slot, delete removes the lowest slot holding
// target_id, tick advances the millisecond count and fires every due timer in
// ascending slot order; func three is taken and ignored. Results come out on
// "result" for exactly one cycle each, marked by result_strobe; there is no
// way to stall them, so the receiver must take every strobed transfer. The
// final result of an item carries last_result. Slot records live in one
// memory with a registered read port and are visited one slot per cycle,
// except during a re-arm, by a read pipeline; a single 32-bit adder serves
// now+delay, the wrap-aware due test (now - due) and the re-arm sum. A
// create or delete ends at the first free or matching slot, or after a full
// scan (table full or id not found); a tick scans every slot and makes an
// extra pass per re-armed periodic timer, since the re-arm sum needs its own
// adder pass and slot write; busy is high all along. No reset sweep is needed.
module periodic_task_timer_table #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ptt_pkg::item_t  item,
  output logic            busy,
  output logic            result_strobe,
  output ptt_pkg::result_t result
);

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_REARM = 2'd2;

  logic [1:0]             state, state_next;
  ptt_pkg::item_t         item_q;
  logic [31:0]            now_ms;
  logic [31:0]            next_id, next_id_next;
  logic [TIMER_SLOTS-1:0] slot_valid;

  // Scan pipeline: issue counter feeds the read port, check stage trails it.
  logic [CW-1:0]          issue_cnt, issue_next;
  logic                   chk_vld, chk_vld_next;
  logic [IW-1:0]          chk_idx, chk_idx_next;

  // Fire result held back one step so the final one can be marked.
  logic                   pend_vld, pend_vld_next;
  logic [31:0]            pend_id, pend_id_next;
  logic                   pend_rearm, pend_rearm_next;

  ptt_pkg::slot_t         hold;
  logic [IW-1:0]          hold_idx;
  logic                   hold_load;

  logic                   ram_we, ram_re;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  ptt_pkg::slot_t         ram_wdata, rd_slot;
  logic [$bits(ptt_pkg::slot_t)-1:0] rd_raw;

  logic                   vset, vclr;
  logic                   strobe_next;
  ptt_pkg::result_t       res_next;

  logic [31:0]            alu_b, alu_sum;
  logic                   alu_cin;
  logic                   accept;

  assign accept  = start && (state == ST_IDLE);
  assign busy    = (state != ST_IDLE);
  assign rd_slot = ptt_pkg::slot_t'(rd_raw);

  ptt_ram #(
    .WIDTH($bits(ptt_pkg::slot_t)),
    .DEPTH(TIMER_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_raw)
  );

  // Shared adder: re-arm sum, create due time, or now - due for the due test.
  always_comb begin
    if (state == ST_REARM) begin
      alu_b   = {1'b0, hold.period};
      alu_cin = 1'b0;
    end else if (item_q.func == ptt_pkg::FUNC_CREATE) begin
      alu_b   = {1'b0, item_q.first_delay_ms};
      alu_cin = 1'b0;
    end else begin
      alu_b   = ~rd_slot.due;
      alu_cin = 1'b1;
    end
  end

  assign alu_sum = now_ms + alu_b + {31'b0, alu_cin};

  // Sequencer.
  always_comb begin
    state_next      = state;
    issue_next      = issue_cnt;
    chk_vld_next    = chk_vld;
    chk_idx_next    = chk_idx;
    pend_vld_next   = pend_vld;
    pend_id_next    = pend_id;
    pend_rearm_next = pend_rearm;
    next_id_next    = next_id;
    hold_load       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = chk_idx;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = issue_cnt[IW-1:0];
    vset            = 1'b0;
    vclr            = 1'b0;
    strobe_next     = 1'b0;
    res_next        = '0;

    case (state)
      ST_IDLE: begin
        if (accept && (item.func != ptt_pkg::FUNC_NONE)) begin
          state_next    = ST_SCAN;
          issue_next    = '0;
          chk_vld_next  = 1'b0;
          pend_vld_next = 1'b0;
        end
      end

      ST_SCAN: begin
        // Advance the read side one slot per cycle.
        if (issue_cnt != SLOTS_C) begin
          ram_re       = 1'b1;
          issue_next   = issue_cnt + CW'(1);
          chk_vld_next = 1'b1;
          chk_idx_next = issue_cnt[IW-1:0];
        end else begin
          chk_vld_next = 1'b0;
        end

        if (chk_vld) begin
          case (item_q.func)
            ptt_pkg::FUNC_CREATE: begin
              if (!slot_valid[chk_idx]) begin
                ram_we       = 1'b1;
                ram_wdata    = '{id: next_id, due: alu_sum, period: item_q.period_ms};
                vset         = 1'b1;
                next_id_next = next_id + 32'd1;
                strobe_next  = 1'b1;
                res_next     = '{event_kind: ptt_pkg::EV_CREATED, timer_id: next_id,
                                 rearmed: 1'b0, last_result: 1'b1};
                state_next   = ST_IDLE;
              end
            end
            ptt_pkg::FUNC_DELETE: begin
              if (slot_valid[chk_idx] && (rd_slot.id == item_q.target_id)) begin
                vclr        = 1'b1;
                strobe_next = 1'b1;
                res_next    = '{event_kind: ptt_pkg::EV_DELETED, timer_id: item_q.target_id,
                                rearmed: 1'b0, last_result: 1'b1};
                state_next  = ST_IDLE;
              end
            end
            ptt_pkg::FUNC_TICK: begin
              if (slot_valid[chk_idx] && !alu_sum[31]) begin
                // Release the previous fire, hold this one back.
                if (pend_vld) begin
                  strobe_next = 1'b1;
                  res_next    = '{event_kind: ptt_pkg::EV_FIRED, timer_id: pend_id,
                                  rearmed: pend_rearm, last_result: 1'b0};
                end
                pend_vld_next   = 1'b1;
                pend_id_next    = rd_slot.id;
                pend_rearm_next = (rd_slot.period != 31'd0);
                if (rd_slot.period != 31'd0) begin
                  hold_load  = 1'b1;
                  state_next = ST_REARM;
                end else begin
                  vclr = 1'b1;
                end
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end else if (issue_cnt == SLOTS_C) begin
          // Scan exhausted: report the closing result (a tick's held fire, if any) and clear the hold.
          strobe_next   = 1'b1;
          state_next    = ST_IDLE;
          pend_vld_next = 1'b0;
          case (item_q.func)
            ptt_pkg::FUNC_CREATE: begin
              res_next = '{event_kind: ptt_pkg::EV_FULL, timer_id: 32'd0,
                           rearmed: 1'b0, last_result: 1'b1};
            end
            ptt_pkg::FUNC_DELETE: begin
              res_next = '{event_kind: ptt_pkg::EV_NOT_FOUND, timer_id: 32'd0,
                           rearmed: 1'b0, last_result: 1'b1};
            end
            default: begin
              if (pend_vld) begin
                res_next = '{event_kind: ptt_pkg::EV_FIRED, timer_id: pend_id,
                             rearmed: pend_rearm, last_result: 1'b1};
              end else begin
                res_next = '{event_kind: ptt_pkg::EV_IDLE, timer_id: 32'd0,
                             rearmed: 1'b0, last_result: 1'b1};
              end
            end
          endcase
        end
      end

      ST_REARM: begin
        // Read port idles so the next slot's data holds; write the new due time.
        ram_we     = 1'b1;
        ram_waddr  = hold_idx;
        ram_wdata  = '{id: hold.id, due: alu_sum, period: hold.period};
        state_next = ST_SCAN;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      now_ms        <= '0;
      next_id       <= '0;
      slot_valid    <= '0;
      issue_cnt     <= '0;
      chk_vld       <= 1'b0;
      pend_vld      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      next_id       <= next_id_next;
      issue_cnt     <= issue_next;
      chk_vld       <= chk_vld_next;
      pend_vld      <= pend_vld_next;
      result_strobe <= strobe_next;
      if (accept && (item.func == ptt_pkg::FUNC_TICK)) begin
        now_ms <= now_ms + 32'd1;
      end
      if (vset) begin
        slot_valid[chk_idx] <= 1'b1;
      end else if (vclr) begin
        slot_valid[chk_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx    <= chk_idx_next;
    pend_id    <= pend_id_next;
    pend_rearm <= pend_rearm_next;
    result     <= res_next;
    if (accept) begin
      item_q <= item;
    end
    if (hold_load) begin
      hold     <= rd_slot;
      hold_idx <= chk_idx;
    end
  end

  // A held-back fire never survives past the end of its tick.
  a_pend_cleared: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !pend_vld)
    else $error("pending fire left over while idle");

  // A re-arm pass always returns to the scan.
  a_rearm_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REARM) |=> (state == ST_SCAN))
    else $error("re-arm did not return to scan");

  // The slot memory is written only while an item is in progress.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy)
    else $error("slot write while idle");

  // An idle tick result is always final and carries no id.
  a_idle_final: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (result.event_kind == ptt_pkg::EV_IDLE)) |->
      (result.last_result && (result.timer_id == 32'd0)))
    else $error("idle result malformed");

  // An ignored item produces no transfer.
  a_none_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.func == ptt_pkg::FUNC_NONE)) |=> !result_strobe)
    else $error("result after ignored item");

endmodule

[tb/tb_periodic_task_timer_table.sv]
// Self-checking testbench for periodic_task_timer_table: create, delete and tick
// transfers with a timer-table predictor. Depends on ptt_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_periodic_task_timer_table;

  localparam int          N_SLOTS      = 16;
  localparam logic [30:0] MAX_SPAN     = 31'h7FFF_FFFF;
  localparam int          RANDOM_ITEMS = 270;
  // A tick scans every slot and may re-arm each one; DRAIN_CYCLES covers both with margin.
  localparam int          DRAIN_CYCLES = 2 * N_SLOTS + 8;

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  ptt_pkg::item_t   item  = '0;
  logic             busy;
  logic             result_strobe;
  ptt_pkg::result_t result;

  always #4 clk = ~clk;

  periodic_task_timer_table #(
    .TIMER_SLOTS(N_SLOTS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_strobe(result_strobe),
    .result       (result)
  );

  // Shadow copy of the timer table, advanced once per accepted transfer.
  logic        tbl_valid [N_SLOTS];
  logic [31:0] tbl_id    [N_SLOTS];
  logic [31:0] tbl_due   [N_SLOTS];
  logic [30:0] tbl_period[N_SLOTS];
  logic [31:0] tbl_next_id;
  logic [31:0] tbl_now;

  ptt_pkg::item_t   stim_q[$];          // items waiting for the driver
  ptt_pkg::result_t pending_events[$];  // results predicted but not yet seen
  ptt_pkg::result_t want_ev;
  int      idle_left = 0;
  int      calm_left = 0;
  int      errors    = 0;
  int      planned   = 0;
  bit      drv_free;

  // Apply one accepted item to the shadow table and queue the results it causes.
  task automatic predict_timer_events(input ptt_pkg::item_t it);
    ptt_pkg::result_t ev;
    ptt_pkg::result_t fired[$];
    logic [31:0]      lag;
    bit               done;
    begin
      ev   = '0;
      done = 1'b0;
      ev.last_result = 1'b1;
      case (it.func)
        ptt_pkg::FUNC_CREATE: begin
          ev.event_kind = ptt_pkg::EV_FULL;
          // take the lowest free slot
          for (int i = 0; i < N_SLOTS; i++) begin
            if (!done && !tbl_valid[i]) begin
              done          = 1'b1;
              tbl_valid[i]  = 1'b1;
              tbl_id[i]     = tbl_next_id;
              tbl_period[i] = it.period_ms;
              tbl_due[i]    = tbl_now + {1'b0, it.first_delay_ms};
              ev.event_kind = ptt_pkg::EV_CREATED;
              ev.timer_id   = tbl_next_id;
              tbl_next_id   = tbl_next_id + 32'd1;
            end
          end
          pending_events.push_back(ev);
        end
        ptt_pkg::FUNC_DELETE: begin
          ev.event_kind = ptt_pkg::EV_NOT_FOUND;
          // only the lowest matching slot goes away
          for (int i = 0; i < N_SLOTS; i++) begin
            if (!done && tbl_valid[i] && tbl_id[i] == it.target_id) begin
              done          = 1'b1;
              tbl_valid[i]  = 1'b0;
              ev.event_kind = ptt_pkg::EV_DELETED;
              ev.timer_id   = it.target_id;
            end
          end
          pending_events.push_back(ev);
        end
        ptt_pkg::FUNC_TICK: begin
          tbl_now = tbl_now + 32'd1;
          for (int i = 0; i < N_SLOTS; i++) begin
            lag = tbl_now - tbl_due[i];
            // due when the wrap-aware difference is non-negative
            if (tbl_valid[i] && !lag[31]) begin
              ev             = '0;
              ev.event_kind  = ptt_pkg::EV_FIRED;
              ev.timer_id    = tbl_id[i];
              if (tbl_period[i] != '0) begin
                tbl_due[i] = tbl_now + {1'b0, tbl_period[i]};
                ev.rearmed = 1'b1;
              end else begin
                tbl_valid[i] = 1'b0;
              end
              fired.push_back(ev);
            end
          end
          if (fired.size() == 0) begin
            ev            = '0;
            ev.event_kind = ptt_pkg::EV_IDLE;
            ev.last_result = 1'b1;
            fired.push_back(ev);
          end
          fired[fired.size() - 1].last_result = 1'b1;
          foreach (fired[k]) pending_events.push_back(fired[k]);
        end
        default: ;  // unused function code: taken, nothing comes out
      endcase
    end
  endtask

  // Idle gap before the next item, drawn at random, with occasional stretches of none.
  function automatic int draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(5, 20);
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [30:0] rand31();
    logic [31:0] r;
    r = $urandom();
    return r[30:0];
  endfunction

  // Id of a random live timer in the shadow table, or any id if none is live.
  function automatic logic [31:0] pick_live_id();
    logic [31:0] live[$];
    for (int i = 0; i < N_SLOTS; i++) if (tbl_valid[i]) live.push_back(tbl_id[i]);
    if (live.size() == 0) return $urandom();
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic int free_slots();
    int n;
    n = 0;
    for (int i = 0; i < N_SLOTS; i++) if (!tbl_valid[i]) n++;
    return n;
  endfunction

  task automatic push_item(input logic [1:0] f, input logic [30:0] per,
                           input logic [30:0] dly, input logic [31:0] tgt);
    ptt_pkg::item_t it;
    begin
      it.func           = f;
      it.period_ms      = per;
      it.first_delay_ms = dly;
      it.target_id      = tgt;
      stim_q.push_back(it);
      if (f != ptt_pkg::FUNC_NONE) planned++;
    end
  endtask

  // Block until the driver has handed over every queued item.
  task automatic drain();
    while (stim_q.size() != 0 || start) @(negedge clk);
  endtask

  // Driver: hold start until busy drops, advance through the item queue, and
  // predict each item at the edge where its transfer happens.
  always @(posedge clk) begin
    if (rst) begin
      start       <= 1'b0;
      idle_left   <= 0;
      tbl_next_id = '0;
      tbl_now     = '0;
      for (int i = 0; i < N_SLOTS; i++) begin
        tbl_valid[i]  = 1'b0;
        tbl_id[i]     = '0;
        tbl_due[i]    = '0;
        tbl_period[i] = '0;
      end
    end else begin
      drv_free = !start || !busy;
      if (start && !busy) predict_timer_events(item);
      if (drv_free) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start     <= 1'b0;
        end else if (stim_q.size() != 0) begin
          item      <= stim_q.pop_front();
          start     <= 1'b1;
          idle_left <= draw_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is taken and matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, got kind=%0d id=%h rearm=%0b last=%0b",
                 $time, result.event_kind, result.timer_id, result.rearmed,
                 result.last_result);
      end else begin
        want_ev = pending_events.pop_front();
        if (result.event_kind !== want_ev.event_kind || result.timer_id !== want_ev.timer_id ||
            result.rearmed !== want_ev.rearmed || result.last_result !== want_ev.last_result)
        begin
          errors++;
          $display("%0t ns: mismatch, expected kind=%0d id=%h rearm=%0b last=%0b",
                   $time, want_ev.event_kind, want_ev.timer_id, want_ev.rearmed,
                   want_ev.last_result);
          $display("%0t ns:           actual kind=%0d id=%h rearm=%0b last=%0b",
                   $time, result.event_kind, result.timer_id, result.rearmed,
                   result.last_result);
        end
      end
    end
  end

  // Reset once, then hold it low for the rest of the run.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin : stimulus
    int          kind;
    int          n;
    int          idx;
    int          sel;
    logic [31:0] live[$];
    logic [30:0] per;
    logic [30:0] dly;

    while (rst) @(negedge clk);

    // Directed: empty table, field extremes, one-shot and periodic firing,
    // deletes that hit and miss, the ignored code, lowest-free-slot reuse.
    push_item(ptt_pkg::FUNC_TICK, rand31(), rand31(), $urandom());       // idle tick
    push_item(ptt_pkg::FUNC_DELETE, rand31(), rand31(), 32'h0000_0000);  // nothing issued yet
    push_item(ptt_pkg::FUNC_DELETE, rand31(), rand31(), 32'hFFFF_FFFF);
    push_item(ptt_pkg::FUNC_CREATE, 31'd0, 31'd0, $urandom());   // id 0, one-shot, zero delay
    push_item(ptt_pkg::FUNC_TICK, rand31(), rand31(), $urandom());  // id 0 fires and is freed
    push_item(ptt_pkg::FUNC_CREATE, MAX_SPAN, MAX_SPAN, $urandom()); // id 1, never comes due
    push_item(ptt_pkg::FUNC_CREATE, 31'd1, 31'd0, $urandom());   // id 2, every tick
    push_item(ptt_pkg::FUNC_CREATE, 31'd0, 31'd2, $urandom());   // id 3
    push_item(ptt_pkg::FUNC_CREATE, 31'd3, 31'd1, $urandom());   // id 4
    push_item(ptt_pkg::FUNC_TICK, rand31(), rand31(), $urandom());  // several fire at once
    push_item(ptt_pkg::FUNC_TICK, rand31(), rand31(), $urandom());
    push_item(ptt_pkg::FUNC_TICK, rand31(), rand31(), $urandom());
    push_item(ptt_pkg::FUNC_DELETE, rand31(), rand31(), 32'd2);
    push_item(ptt_pkg::FUNC_DELETE, rand31(), rand31(), 32'd2);  // already gone
    push_item(ptt_pkg::FUNC_DELETE, rand31(), rand31(), 32'd1);
    push_item(ptt_pkg::FUNC_NONE, MAX_SPAN, MAX_SPAN, 32'hFFFF_FFFF);  // ignored
    push_item(ptt_pkg::FUNC_CREATE, 31'd0, 31'd0, $urandom());   // reuses slot 0
    push_item(ptt_pkg::FUNC_TICK, rand31(), rand31(), $urandom());
    push_item(ptt_pkg::FUNC_DELETE, rand31(), rand31(), 32'd4);

    // Random batches, each planned from the table as it stands once drained.
    planned = 0;
    while (planned < RANDOM_ITEMS) begin
      drain();
      kind = $urandom_range(0, 9);
      if (kind == 5) begin
        // fill the table past full, then punch holes and refill them
        n = free_slots();
        for (int k = 0; k < n + int'($urandom_range(1, 2)); k++)
          push_item(ptt_pkg::FUNC_CREATE, 31'($urandom_range(0, 4)),
                    31'($urandom_range(1, 20)), $urandom());
        for (int k = 0; k < int'($urandom_range(1, 3)); k++)
          push_item(ptt_pkg::FUNC_DELETE, rand31(), rand31(),
                    (n > 0) ? tbl_next_id + $urandom_range(0, n - 1) : pick_live_id());
        for (int k = 0; k < int'($urandom_range(1, 2)); k++)
          push_item(ptt_pkg::FUNC_CREATE, 31'($urandom_range(0, 3)),
                    31'($urandom_range(0, 5)), $urandom());
        push_item(ptt_pkg::FUNC_TICK, rand31(), rand31(), $urandom());
      end else if (kind == 6) begin
        // run the clock forward
        for (int k = 0; k < int'($urandom_range(5, 15)); k++)
          push_item(ptt_pkg::FUNC_TICK, rand31(), rand31(), $urandom());
      end else if (kind == 7) begin
        // clear out every live timer in random order, with an occasional repeated delete
        live.delete();
        for (int i = 0; i < N_SLOTS; i++) if (tbl_valid[i]) live.push_back(tbl_id[i]);
        while (live.size() != 0) begin
          idx = $urandom_range(0, live.size() - 1);
          push_item(ptt_pkg::FUNC_DELETE, rand31(), rand31(), live[idx]);
          if ($urandom_range(0, 7) == 0)
            push_item(ptt_pkg::FUNC_DELETE, rand31(), rand31(), live[idx]);
          live.delete(idx);
        end
      end else begin
        // mixed traffic, mostly short delays so that ticks keep firing
        for (int k = 0; k < int'($urandom_range(6, 10)); k++) begin
          sel = $urandom_range(0, 99);
          if (sel < 40) begin
            push_item(ptt_pkg::FUNC_TICK, rand31(), rand31(), $urandom());
          end else if (sel < 75) begin
            idx = $urandom_range(0, 9);
            per = (idx < 5) ? 31'd0 : (idx < 9) ? 31'($urandom_range(1, 6)) : rand31();
            dly = ($urandom_range(0, 9) == 0) ? rand31() : 31'($urandom_range(0, 6));
            push_item(ptt_pkg::FUNC_CREATE, per, dly, $urandom());
          end else if (sel < 95) begin
            push_item(ptt_pkg::FUNC_DELETE, rand31(), rand31(),
                      ($urandom_range(0, 9) < 7) ? pick_live_id() : $urandom());
          end else begin
            push_item(ptt_pkg::FUNC_NONE, rand31(), rand31(), $urandom());
          end
        end
      end
    end

    // Let every transfer land, then wait out the block's longest item.
    drain();
    while (pending_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_events.size() != 0) begin
      errors++;
      $display("%0t ns: %0d predicted results never arrived", $time, pending_events.size());
    end
    if (errors == 0) begin
      $display("[periodic_task_timer_table] OK");
    end else begin
      $display("[periodic_task_timer_table] ERROR");
    end
    $finish;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("[periodic_task_timer_table] ERROR");
    $finish;
  end

endmodule
